// File: src/tlv_buffer_validator_defines.svh
// ----------------------------------------------------------------------------
// TLV buffer validator assertion macros
// Shared checking macros. Simulation builds get concurrent assertions;
// synthesis builds get empty bodies.
// ----------------------------------------------------------------------------
`ifndef TLV_BUFFER_VALIDATOR_DEFINES_SVH
`define TLV_BUFFER_VALIDATOR_DEFINES_SVH

`ifndef SYNTHESIS

// The property must hold at every clock edge outside reset.
`define TLVBV_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// The antecedent implies the consequent in the same cycle.
`define TLVBV_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The antecedent implies the consequent in the following cycle.
`define TLVBV_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define TLVBV_ASSERT(label, clk, rst, prop, msg)
`define TLVBV_ASSERT_SAME(label, clk, rst, ante, cons, msg)
`define TLVBV_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

// File: src/tlvbv_pkg.sv
// ----------------------------------------------------------------------------
// TLV buffer validator package
// Types, parse phase codes, status codes and helpers shared by the block.
// ----------------------------------------------------------------------------
`default_nettype none

package tlvbv_pkg;

  // Width of the internal element counter.
  localparam int COUNT_WIDTH = 16;
  localparam int TOTAL_WIDTH = 16;
  localparam int BYTE_WIDTH  = 8;
  localparam int STATUS_WIDTH = 2;
  localparam int PHASE_WIDTH = 3;
  localparam int OUT_DATA_WIDTH = 24;

  // Reset value of the undefined type code register.
  localparam logic [BYTE_WIDTH-1:0] UNDEF_TYPE_RESET = 8'd6;

  // Parse phases.
  localparam logic [PHASE_WIDTH-1:0] PH_TYPE   = 3'd0;
  localparam logic [PHASE_WIDTH-1:0] PH_CNT_HI = 3'd1;
  localparam logic [PHASE_WIDTH-1:0] PH_CNT_LO = 3'd2;
  localparam logic [PHASE_WIDTH-1:0] PH_LEN_HI = 3'd3;
  localparam logic [PHASE_WIDTH-1:0] PH_LEN_LO = 3'd4;
  localparam logic [PHASE_WIDTH-1:0] PH_DATA   = 3'd5;

  // Status codes.
  localparam logic [STATUS_WIDTH-1:0] ST_VALID   = 2'd0;
  localparam logic [STATUS_WIDTH-1:0] ST_BADTYPE = 2'd1;
  localparam logic [STATUS_WIDTH-1:0] ST_OVERRUN = 2'd2;

  // One buffer byte as held in the input register.
  typedef struct packed {
    logic                  last;
    logic [BYTE_WIDTH-1:0] value;
  } byte_item_t;

  // One result item.
  typedef struct packed {
    logic [TOTAL_WIDTH-1:0]  total;
    logic [STATUS_WIDTH-1:0] status;
  } result_t;

  // Clamp the element counter to the width of the reported total.
  function automatic logic [TOTAL_WIDTH-1:0] sat_total(input logic [COUNT_WIDTH-1:0] cnt);
    logic [31:0] ext;
    ext = 32'(cnt);
    if (ext > 32'h0000_FFFF) begin
      return '1;
    end
    return ext[TOTAL_WIDTH-1:0];
  endfunction

endpackage

`default_nettype wire

// File: src/tlvbv_in_stage.sv
// ----------------------------------------------------------------------------
// TLV buffer validator input stage
// Registers one incoming byte and hands it to the parser when the result
// side has room for whatever it may produce.
// ----------------------------------------------------------------------------
`default_nettype none

module tlvbv_in_stage
  import tlvbv_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output      logic                  s_tready,
  input  wire logic [BYTE_WIDTH-1:0] s_tdata,
  input  wire logic                  s_tlast,
  input  wire logic                  out_free,
  output      byte_item_t            item,
  output      logic                  item_valid,
  output      logic                  pop
);

  logic       valid_q;
  byte_item_t item_q;

  // A byte that produces no result always leaves; a last byte waits for room.
  assign pop        = valid_q && (!item_q.last || out_free);
  assign s_tready   = !valid_q || pop;
  assign item       = item_q;
  assign item_valid = valid_q;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (s_tready) begin
      valid_q <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item_q.value <= s_tdata;
      item_q.last  <= s_tlast;
    end
  end

endmodule

`default_nettype wire

// File: src/tlvbv_parser.sv
// ----------------------------------------------------------------------------
// TLV buffer validator parser
// Holds the parse state and advances it by one byte per item, producing a
// status and element count on the last byte of a buffer.
// ----------------------------------------------------------------------------
`default_nettype none

module tlvbv_parser
  import tlvbv_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic [BYTE_WIDTH-1:0] undef_type,
  input  wire byte_item_t            item,
  input  wire logic                  pop,
  output      result_t               result,
  output      logic                  result_valid
);

  logic [PHASE_WIDTH-1:0]  phase, phase_next;
  logic [BYTE_WIDTH-1:0]   hold, hold_next;
  logic [15:0]             entries, entries_next;
  logic [15:0]             data_cnt, data_cnt_next;
  logic [COUNT_WIDTH-1:0]  elements, elements_next;
  logic [STATUS_WIDTH-1:0] err, err_next;

  // Byte-level parse step.
  always_comb begin
    logic [PHASE_WIDTH-1:0]  ph;
    logic [BYTE_WIDTH-1:0]   hd;
    logic [15:0]             ent;
    logic [15:0]             dat;
    logic [COUNT_WIDTH-1:0]  cnt;
    logic [STATUS_WIDTH-1:0] er;
    logic                    entry_end;

    ph        = phase;
    hd        = hold;
    ent       = entries;
    dat       = data_cnt;
    cnt       = elements;
    er        = err;
    entry_end = 1'b0;

    if (err == ST_VALID) begin
      unique case (phase)
        PH_TYPE: begin
          if (item.value == '0 || item.value >= undef_type) begin
            er = ST_BADTYPE;
          end else begin
            ph = PH_CNT_HI;
          end
        end
        PH_CNT_HI: begin
          hd = item.value;
          ph = PH_CNT_LO;
        end
        PH_CNT_LO: begin
          ent = {hold, item.value};
          if (ent == '0) begin
            if (cnt != '1) cnt = cnt + 1'b1;
            ph = PH_TYPE;
          end else begin
            ph = PH_LEN_HI;
          end
        end
        PH_LEN_HI: begin
          hd = item.value;
          ph = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          dat = {hold, item.value};
          if (dat == '0) begin
            entry_end = 1'b1;
          end else begin
            ph = PH_DATA;
          end
        end
        PH_DATA: begin
          dat = data_cnt - 1'b1;
          if (dat == '0) entry_end = 1'b1;
        end
        default: begin
          ph = PH_TYPE;
        end
      endcase

      // An entry is complete: count it off, and close the element if it was the final one.
      if (entry_end) begin
        ent = entries - 1'b1;
        if (ent == '0) begin
          if (cnt != '1) cnt = cnt + 1'b1;
          ph = PH_TYPE;
        end else begin
          ph = PH_LEN_HI;
        end
      end
    end

    // A buffer that ends anywhere but between elements is truncated.
    if (item.last && er == ST_VALID && ph != PH_TYPE) begin
      er = ST_OVERRUN;
    end

    result.status = er;
    result.total  = sat_total(cnt);
    result_valid  = pop && item.last;

    // The last byte returns the parser to its starting state.
    if (item.last) begin
      phase_next    = PH_TYPE;
      hold_next     = '0;
      entries_next  = '0;
      data_cnt_next = '0;
      elements_next = '0;
      err_next      = ST_VALID;
    end else begin
      phase_next    = ph;
      hold_next     = hd;
      entries_next  = ent;
      data_cnt_next = dat;
      elements_next = cnt;
      err_next      = er;
    end
  end

  // Parse state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_TYPE;
      hold     <= '0;
      entries  <= '0;
      data_cnt <= '0;
      elements <= '0;
      err      <= ST_VALID;
    end else if (pop) begin
      phase    <= phase_next;
      hold     <= hold_next;
      entries  <= entries_next;
      data_cnt <= data_cnt_next;
      elements <= elements_next;
      err      <= err_next;
    end
  end

endmodule

`default_nettype wire

// File: src/tlvbv_out_reg.sv
// ----------------------------------------------------------------------------
// TLV buffer validator result register
// Holds one result item until the downstream side takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module tlvbv_out_reg
  import tlvbv_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire result_t                   result,
  input  wire logic                      result_valid,
  output      logic                      out_free,
  output      logic                      m_tvalid,
  input  wire logic                      m_tready,
  output      logic [OUT_DATA_WIDTH-1:0] m_tdata
);

  logic    valid_q;
  result_t result_q;

  // The register can take a new result when empty or being emptied.
  assign out_free = !valid_q || m_tready;
  assign m_tvalid = valid_q;
  assign m_tdata  = OUT_DATA_WIDTH'(result_q);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (out_free) begin
      valid_q <= result_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (result_valid) begin
      result_q <= result;
    end
  end

endmodule

`default_nettype wire

// File: src/tlv_buffer_validator.sv
// ----------------------------------------------------------------------------
// TLV buffer validator
// Streaming checker for serialized type/count/length/data buffers.
// ----------------------------------------------------------------------------
// The block takes one buffer byte per cycle on the slave stream, with tlast
// marking the final byte of a buffer, and sustains one item per clock while
// no last byte is held back by the result register. Each byte passes an
// input register, one step of the parser state, and for the last byte a
// result register. A result is registered once its last byte leaves the
// input register. A last byte waits in the input register only while the
// result register still holds an untaken result, and the input stream waits
// behind it. The result carries a status (valid, bad type byte, overrun) and
// the count of complete elements, saturating at 65535. The undefined type
// code register may only be written while no buffer is in flight.
`default_nettype none

`include "tlv_buffer_validator_defines.svh"

module tlv_buffer_validator
  import tlvbv_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst,
  // Configuration: undefined type code.
  input  wire logic                      cfg_wr_en,
  input  wire logic [BYTE_WIDTH-1:0]     cfg_wr_data,
  // Input stream.
  input  wire logic                      s_tvalid,
  output      logic                      s_tready,
  input  wire logic [BYTE_WIDTH-1:0]     s_tdata,   // [7:0] byte_value
  input  wire logic                      s_tlast,   // last_byte
  // Result stream.
  output      logic                      m_tvalid,
  input  wire logic                      m_tready,
  output      logic [OUT_DATA_WIDTH-1:0] m_tdata    // [1:0] status, [17:2] element_total
);

  logic [BYTE_WIDTH-1:0] undef_type;
  byte_item_t            item;
  logic                  item_valid;
  logic                  pop;
  logic                  out_free;
  result_t               result;
  logic                  result_valid;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      undef_type <= UNDEF_TYPE_RESET;
    end else if (cfg_wr_en) begin
      undef_type <= cfg_wr_data;
    end
  end

  tlvbv_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .out_free   (out_free),
    .item       (item),
    .item_valid (item_valid),
    .pop        (pop)
  );

  tlvbv_parser u_parser (
    .clk          (clk),
    .rst          (rst),
    .undef_type   (undef_type),
    .item         (item),
    .pop          (pop),
    .result       (result),
    .result_valid (result_valid)
  );

  tlvbv_out_reg u_out_reg (
    .clk          (clk),
    .rst          (rst),
    .result       (result),
    .result_valid (result_valid),
    .out_free     (out_free),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata)
  );

  // Status is never the unused code.
  `TLVBV_ASSERT_SAME(a_status_legal, clk, rst, m_tvalid, m_tdata[1:0] != 2'd3, "illegal status code")

  // A new result only follows a last byte leaving the input register.
  `TLVBV_ASSERT_SAME(a_result_from_last, clk, rst, $rose(m_tvalid), $past(pop && item.last), "result without last byte")

  // A last byte blocked by a full result register stays in the input register.
  `TLVBV_ASSERT_NEXT(a_last_held, clk, rst, item_valid && item.last && !out_free, item_valid && $stable(item), "blocked last byte lost")

  // Bytes other than the last never produce a result.
  `TLVBV_ASSERT(a_no_result_mid, clk, rst, !(result_valid && !item.last), "result from non-last byte")

endmodule

`default_nettype wire
